// ----- rtl/core/ami_pkg.sv -----
// Shared types, constants and the sequencer microcode for the affine matrix inverse.
// Depends on nothing; used by ami_fpu and affine_matrix_inverse.
package ami_pkg;

	typedef enum logic [2:0] {FOP_MUL, FOP_ADD, FOP_SUB, FOP_RCP, FOP_NEG} fpu_op_t;

	typedef struct packed {
		logic        start;
		fpu_op_t     op;
		logic [31:0] a;
		logic [31:0] b;
	} fpu_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] result;
	} fpu_rsp_t;

	typedef struct packed {
		logic        chk;
		fpu_op_t     op;
		logic [4:0]  dst;
		logic [4:0]  a;
		logic [4:0]  b;
		logic        negb;
	} uop_t;

	typedef enum logic [2:0] {
		ST_LOAD, ST_READ, ST_EXEC, ST_WAIT, ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_HOLD
	} seq_state_t;

	typedef enum logic [2:0] {F_IDLE, F_CALC, F_DIV, F_LZC, F_SHIFT, F_ROUND} fpu_state_t;

	localparam int MEM_DEPTH = 32;
	localparam logic [3:0] NUM_ELEMS = 4'd12;
	localparam logic [3:0] LAST_ELEM = 4'd11;
	localparam logic [3:0] DIAG0 = 4'd0;
	localparam logic [3:0] DIAG1 = 4'd5;
	localparam logic [3:0] DIAG2 = 4'd10;
	localparam logic [6:0] LAST_STEP = 7'd72;
	localparam logic [31:0] ONE_BITS = 32'h3F80_0000;
	localparam logic [30:0] DET_LIMIT = 31'h3727_C5AC;
	localparam logic [31:0] QNAN_BITS = 32'hFFC0_0000;
	localparam logic [31:0] QUIET_BIT = 32'h0040_0000;

	// register file map: matrix, temporaries, results
	localparam logic [4:0] A_M00 = 5'd0,  A_M01 = 5'd1,  A_M02 = 5'd2,  A_M03 = 5'd3;
	localparam logic [4:0] A_M10 = 5'd4,  A_M11 = 5'd5,  A_M12 = 5'd6,  A_M13 = 5'd7;
	localparam logic [4:0] A_M20 = 5'd8,  A_M21 = 5'd9,  A_M22 = 5'd10, A_M23 = 5'd11;
	localparam logic [4:0] A_D = 5'd12, A_P = 5'd13, A_Q = 5'd14, A_R = 5'd15;
	localparam logic [4:0] A_V00 = 5'd16, A_V01 = 5'd17, A_V02 = 5'd18, A_V03 = 5'd19;
	localparam logic [4:0] A_V10 = 5'd20, A_V11 = 5'd21, A_V12 = 5'd22, A_V13 = 5'd23;
	localparam logic [4:0] A_V20 = 5'd24, A_V21 = 5'd25, A_V22 = 5'd26, A_V23 = 5'd27;

	function automatic uop_t mk(input fpu_op_t op, input logic [4:0] dst,
		input logic [4:0] a, input logic [4:0] b, input logic negb);
		uop_t u;
		u.chk  = 1'b0;
		u.op   = op;
		u.dst  = dst;
		u.a    = a;
		u.b    = b;
		u.negb = negb;
		return u;
	endfunction

	function automatic uop_t ucode(input logic [6:0] step);
		uop_t u;
		u = mk(FOP_NEG, A_P, A_P, A_P, 1'b0);
		case (step)
			// determinant
			7'd0:  u = mk(FOP_MUL, A_P, A_M01, A_M12, 1'b0);
			7'd1:  u = mk(FOP_MUL, A_D, A_P, A_M20, 1'b0);
			7'd2:  u = mk(FOP_MUL, A_P, A_M00, A_M11, 1'b0);
			7'd3:  u = mk(FOP_MUL, A_P, A_M22, A_P, 1'b0);
			7'd4:  u = mk(FOP_ADD, A_D, A_P, A_D, 1'b0);
			7'd5:  u = mk(FOP_MUL, A_P, A_M10, A_M02, 1'b0);
			7'd6:  u = mk(FOP_MUL, A_P, A_M21, A_P, 1'b0);
			7'd7:  u = mk(FOP_ADD, A_D, A_P, A_D, 1'b0);
			7'd8:  u = mk(FOP_MUL, A_P, A_M20, A_M11, 1'b0);
			7'd9:  u = mk(FOP_MUL, A_P, A_M02, A_P, 1'b0);
			7'd10: u = mk(FOP_SUB, A_D, A_D, A_P, 1'b0);
			7'd11: u = mk(FOP_MUL, A_P, A_M10, A_M01, 1'b0);
			7'd12: u = mk(FOP_MUL, A_P, A_M22, A_P, 1'b0);
			7'd13: u = mk(FOP_SUB, A_D, A_D, A_P, 1'b0);
			7'd14: u = mk(FOP_MUL, A_P, A_M00, A_M21, 1'b0);
			7'd15: u = mk(FOP_MUL, A_P, A_M12, A_P, 1'b0);
			7'd16: u = mk(FOP_SUB, A_D, A_D, A_P, 1'b0);
			7'd17: begin
				u = mk(FOP_NEG, A_D, A_D, A_D, 1'b0);
				u.chk = 1'b1;
			end
			7'd18: u = mk(FOP_RCP, A_R, A_D, A_D, 1'b0);
			// cofactors times reciprocal
			7'd19: u = mk(FOP_MUL, A_P, A_M11, A_M22, 1'b0);
			7'd20: u = mk(FOP_MUL, A_Q, A_M21, A_M12, 1'b0);
			7'd21: u = mk(FOP_SUB, A_P, A_P, A_Q, 1'b0);
			7'd22: u = mk(FOP_MUL, A_V00, A_R, A_P, 1'b0);
			7'd23: u = mk(FOP_MUL, A_P, A_M01, A_M22, 1'b0);
			7'd24: u = mk(FOP_MUL, A_Q, A_M21, A_M02, 1'b0);
			7'd25: u = mk(FOP_SUB, A_P, A_P, A_Q, 1'b0);
			7'd26: u = mk(FOP_MUL, A_V01, A_R, A_P, 1'b1);
			7'd27: u = mk(FOP_MUL, A_P, A_M01, A_M12, 1'b0);
			7'd28: u = mk(FOP_MUL, A_Q, A_M11, A_M02, 1'b0);
			7'd29: u = mk(FOP_SUB, A_P, A_P, A_Q, 1'b0);
			7'd30: u = mk(FOP_MUL, A_V02, A_R, A_P, 1'b0);
			7'd31: u = mk(FOP_MUL, A_P, A_M10, A_M22, 1'b0);
			7'd32: u = mk(FOP_MUL, A_Q, A_M20, A_M12, 1'b0);
			7'd33: u = mk(FOP_SUB, A_P, A_P, A_Q, 1'b0);
			7'd34: u = mk(FOP_MUL, A_V10, A_R, A_P, 1'b1);
			7'd35: u = mk(FOP_MUL, A_P, A_M00, A_M22, 1'b0);
			7'd36: u = mk(FOP_MUL, A_Q, A_M20, A_M02, 1'b0);
			7'd37: u = mk(FOP_SUB, A_P, A_P, A_Q, 1'b0);
			7'd38: u = mk(FOP_MUL, A_V11, A_R, A_P, 1'b0);
			7'd39: u = mk(FOP_MUL, A_P, A_M00, A_M12, 1'b0);
			7'd40: u = mk(FOP_MUL, A_Q, A_M10, A_M02, 1'b0);
			7'd41: u = mk(FOP_SUB, A_P, A_P, A_Q, 1'b0);
			7'd42: u = mk(FOP_MUL, A_V12, A_R, A_P, 1'b1);
			7'd43: u = mk(FOP_MUL, A_P, A_M10, A_M21, 1'b0);
			7'd44: u = mk(FOP_MUL, A_Q, A_M20, A_M11, 1'b0);
			7'd45: u = mk(FOP_SUB, A_P, A_P, A_Q, 1'b0);
			7'd46: u = mk(FOP_MUL, A_V20, A_R, A_P, 1'b0);
			7'd47: u = mk(FOP_MUL, A_P, A_M00, A_M21, 1'b0);
			7'd48: u = mk(FOP_MUL, A_Q, A_M20, A_M01, 1'b0);
			7'd49: u = mk(FOP_SUB, A_P, A_P, A_Q, 1'b0);
			7'd50: u = mk(FOP_MUL, A_V21, A_R, A_P, 1'b1);
			7'd51: u = mk(FOP_MUL, A_P, A_M00, A_M11, 1'b0);
			7'd52: u = mk(FOP_MUL, A_Q, A_M10, A_M01, 1'b0);
			7'd53: u = mk(FOP_SUB, A_P, A_P, A_Q, 1'b0);
			7'd54: u = mk(FOP_MUL, A_V22, A_R, A_P, 1'b0);
			// translation column
			7'd55: u = mk(FOP_MUL, A_P, A_V00, A_M03, 1'b0);
			7'd56: u = mk(FOP_MUL, A_Q, A_V01, A_M13, 1'b0);
			7'd57: u = mk(FOP_ADD, A_P, A_P, A_Q, 1'b0);
			7'd58: u = mk(FOP_MUL, A_Q, A_V02, A_M23, 1'b0);
			7'd59: u = mk(FOP_ADD, A_P, A_P, A_Q, 1'b0);
			7'd60: u = mk(FOP_NEG, A_V03, A_P, A_P, 1'b0);
			7'd61: u = mk(FOP_MUL, A_P, A_V10, A_M03, 1'b0);
			7'd62: u = mk(FOP_MUL, A_Q, A_V11, A_M13, 1'b0);
			7'd63: u = mk(FOP_ADD, A_P, A_P, A_Q, 1'b0);
			7'd64: u = mk(FOP_MUL, A_Q, A_V12, A_M23, 1'b0);
			7'd65: u = mk(FOP_ADD, A_P, A_P, A_Q, 1'b0);
			7'd66: u = mk(FOP_NEG, A_V13, A_P, A_P, 1'b0);
			7'd67: u = mk(FOP_MUL, A_P, A_V20, A_M03, 1'b0);
			7'd68: u = mk(FOP_MUL, A_Q, A_V21, A_M13, 1'b0);
			7'd69: u = mk(FOP_ADD, A_P, A_P, A_Q, 1'b0);
			7'd70: u = mk(FOP_MUL, A_Q, A_V22, A_M23, 1'b0);
			7'd71: u = mk(FOP_ADD, A_P, A_P, A_Q, 1'b0);
			7'd72: u = mk(FOP_NEG, A_V23, A_P, A_P, 1'b0);
			default: u = mk(FOP_NEG, A_P, A_P, A_P, 1'b0);
		endcase
		return u;
	endfunction

endpackage

// ----- rtl/core/affine_matrix_inverse.sv -----
// Affine 3x4 matrix inverse: element store, microcoded sequencer, result output.
// Loads take one element item per cycle; after the last item the block stalls its input.
// Each float step runs on the shared unit, special operands taking a shorter path, and the
// reciprocal adds a bit-serial division; a singular matrix ends the sequence early.
// Results leave one at a time, the next after the last is taken. Reset clears control only; the
// element store is undefined until written. Depends on ami_pkg and ami_fpu.
module affine_matrix_inverse import ami_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] element_value,
	input  logic        element_last,
	input  logic        in_valid,
	output logic        in_stall,
	output logic [31:0] result_value,
	output logic        singular,
	output logic        result_last,
	output logic        out_valid,
	input  logic        out_stall
);

	seq_state_t state_q, state_d;
	logic [6:0] step_q;
	logic [3:0] load_idx_q, emit_idx_q;
	logic sing_q;
	logic [31:0] mem_q [MEM_DEPTH];
	logic [31:0] rd_a_q, rd_b_q;
	logic [4:0] raddr_a, raddr_b, waddr;
	logic we;
	logic [31:0] wdata;
	uop_t uop;
	fpu_req_t fpu_req;
	fpu_rsp_t fpu_rsp;
	logic in_acc, out_acc, det_ok, diag;
	logic out_valid_q, out_last_q;
	logic [31:0] out_value_q;

	ami_fpu u_fpu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (fpu_req),
		.rsp    (fpu_rsp)
	);

	assign in_stall = (state_q != ST_LOAD);
	assign out_valid = out_valid_q;
	assign result_value = out_value_q;
	assign result_last = out_last_q;
	assign singular = sing_q;

	always_comb begin
		uop = ucode(step_q);
		in_acc = in_valid && (state_q == ST_LOAD);
		out_acc = out_valid_q && !out_stall;
		// NaN determinant counts as singular
		det_ok = !((rd_a_q[30:23] == 8'hFF) && (rd_a_q[22:0] != 23'h0)) &&
			(rd_a_q[30:0] > DET_LIMIT);
		diag = (emit_idx_q == DIAG0) || (emit_idx_q == DIAG1) || (emit_idx_q == DIAG2);
		state_d = state_q;
		we = 1'b0;
		waddr = uop.dst;
		wdata = fpu_rsp.result;
		raddr_a = uop.a;
		raddr_b = uop.b;
		fpu_req.start = 1'b0;
		fpu_req.op = uop.op;
		fpu_req.a = rd_a_q;
		fpu_req.b = {rd_b_q[31] ^ uop.negb, rd_b_q[30:0]};
		case (state_q)
			ST_LOAD: begin
				if (in_acc) begin
					we = (load_idx_q < NUM_ELEMS);
					waddr = {1'b0, load_idx_q};
					wdata = element_value;
					if (element_last) state_d = ST_READ;
				end
			end
			ST_READ: state_d = ST_EXEC;
			ST_EXEC: begin
				if (uop.chk) begin
					state_d = det_ok ? ST_READ : ST_EMIT_RD;
				end else begin
					fpu_req.start = 1'b1;
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (fpu_rsp.done) begin
					we = 1'b1;
					state_d = (step_q == LAST_STEP) ? ST_EMIT_RD : ST_READ;
				end
			end
			ST_EMIT_RD: begin
				raddr_a = A_V00 + {1'b0, emit_idx_q};
				state_d = ST_EMIT_LD;
			end
			ST_EMIT_LD: state_d = ST_EMIT_HOLD;
			ST_EMIT_HOLD: begin
				if (out_acc) state_d = (emit_idx_q == LAST_ELEM) ? ST_LOAD : ST_EMIT_RD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			step_q <= 7'd0;
			load_idx_q <= 4'd0;
			emit_idx_q <= 4'd0;
			sing_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (element_last) begin
							load_idx_q <= 4'd0;
							step_q <= 7'd0;
							sing_q <= 1'b0;
						end else if (load_idx_q < NUM_ELEMS) begin
							load_idx_q <= load_idx_q + 4'd1;
						end
					end
				end
				ST_EXEC: begin
					if (uop.chk) begin
						if (det_ok) step_q <= step_q + 7'd1;
						else sing_q <= 1'b1;
					end
				end
				ST_WAIT: begin
					if (fpu_rsp.done && (step_q != LAST_STEP)) step_q <= step_q + 7'd1;
				end
				ST_EMIT_LD: out_valid_q <= 1'b1;
				ST_EMIT_HOLD: begin
					if (out_acc) begin
						out_valid_q <= 1'b0;
						emit_idx_q <= (emit_idx_q == LAST_ELEM) ? 4'd0 : emit_idx_q + 4'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT_LD) begin
			out_value_q <= sing_q ? (diag ? ONE_BITS : 32'h0) : rd_a_q;
			out_last_q <= (emit_idx_q == LAST_ELEM);
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rd_a_q <= mem_q[raddr_a];
		rd_b_q <= mem_q[raddr_b];
	end

`ifndef SYNTHESIS
	a_no_out_while_loading: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !out_valid) else $error("result item pending while loading");
	a_last_starts_compute: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && element_last) |=> (state_q == ST_READ))
		else $error("last element did not start the inverse");
	a_done_only_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		fpu_rsp.done |-> (state_q == ST_WAIT)) else $error("unexpected float unit result");
	a_load_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		load_idx_q <= NUM_ELEMS) else $error("load index past the store");
`endif

endmodule

// ----- rtl/core/ami_fpu.sv -----
// Shared single-precision unit: multiply, add, subtract, reciprocal, negate.
// Round to nearest even, subnormals kept. Depends on ami_pkg.
module ami_fpu import ami_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  fpu_req_t req,
	output fpu_rsp_t rsp
);

	fpu_state_t state_q, state_d;
	fpu_op_t op_q;
	logic [31:0] a_q, b_q;
	logic [47:0] m_q;
	logic signed [10:0] e_q;
	logic sgn_q, st_q;
	logic [5:0] lz_q, cnt_q;
	logic [47:0] n_q;
	logic signed [10:0] x_q;
	logic nst_q;
	logic [24:0] rem_q;
	logic [31:0] res_q;
	logic done_q;

	logic [31:0] bx;
	logic [7:0] ea, eb, ea_e, eb_e;
	logic [23:0] sa, sb;
	logic a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
	logic spec;
	logic [31:0] spec_val;
	logic [47:0] prod;
	logic signed [10:0] mul_e;
	logic a_ge;
	logic [31:0] big, sml;
	logic [23:0] sig_big, sig_sml;
	logic [7:0] e_big, e_sml, dexp;
	logic [95:0] al_wide;
	logic [47:0] al_st, sum;
	logic eff_sub, sum_sgn;
	logic div_ge;
	logic [24:0] div_diff;
	logic signed [10:0] lz_ext;
	logic [10:0] rs_full;
	logic [5:0] rs6;
	logic [95:0] rs_wide;
	logic [47:0] sh_n;
	logic signed [10:0] sh_x;
	logic sh_st;
	logic [23:0] keep;
	logic rnd_up;
	logic [24:0] r25;
	logic [23:0] mant;
	logic signed [10:0] xr;
	logic [31:0] packed_res;

	function automatic logic [5:0] lzc48(input logic [47:0] v);
		logic [5:0] n;
		logic found;
		n = 6'd48;
		found = 1'b0;
		for (int i = 47; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 6'(47 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

	always_comb begin
		bx = (op_q == FOP_SUB) ? {~b_q[31], b_q[30:0]} : b_q;
		ea = a_q[30:23];
		eb = b_q[30:23];
		ea_e = (ea == 8'h00) ? 8'h01 : ea;
		eb_e = (eb == 8'h00) ? 8'h01 : eb;
		sa = {|ea, a_q[22:0]};
		sb = {|eb, b_q[22:0]};
		a_nan = (ea == 8'hFF) && (a_q[22:0] != 23'h0);
		b_nan = (eb == 8'hFF) && (b_q[22:0] != 23'h0);
		a_inf = (ea == 8'hFF) && (a_q[22:0] == 23'h0);
		b_inf = (eb == 8'hFF) && (b_q[22:0] == 23'h0);
		a_zero = (a_q[30:0] == 31'h0);
		b_zero = (b_q[30:0] == 31'h0);

		// multiply
		prod = sa * sb;
		mul_e = $signed({3'b000, ea_e}) + $signed({3'b000, eb_e}) - 11'sd127;

		// add: larger magnitude first, smaller aligned with a sticky lsb
		a_ge = a_q[30:0] >= bx[30:0];
		big = a_ge ? a_q : bx;
		sml = a_ge ? bx : a_q;
		sig_big = {|big[30:23], big[22:0]};
		sig_sml = {|sml[30:23], sml[22:0]};
		e_big = (big[30:23] == 8'h00) ? 8'h01 : big[30:23];
		e_sml = (sml[30:23] == 8'h00) ? 8'h01 : sml[30:23];
		dexp = e_big - e_sml;
		if (dexp >= 8'd48) begin
			al_wide = 96'h0;
			al_st = {47'h0, |sig_sml};
		end else begin
			al_wide = {1'b0, sig_sml, 23'h0, 48'h0} >> dexp[5:0];
			al_st = al_wide[95:48] | {47'h0, |al_wide[47:0]};
		end
		eff_sub = big[31] ^ sml[31];
		sum = eff_sub ? ({1'b0, sig_big, 23'h0} - al_st) : ({1'b0, sig_big, 23'h0} + al_st);
		sum_sgn = (eff_sub && (sum == 48'h0)) ? 1'b0 : big[31];

		// special operands
		spec = 1'b0;
		spec_val = QNAN_BITS;
		case (op_q)
			FOP_MUL: begin
				spec = 1'b1;
				if (a_nan) spec_val = a_q | QUIET_BIT;
				else if (b_nan) spec_val = b_q | QUIET_BIT;
				else if ((a_inf && b_zero) || (a_zero && b_inf)) spec_val = QNAN_BITS;
				else if (a_inf || b_inf) spec_val = {a_q[31] ^ b_q[31], 8'hFF, 23'h0};
				else spec = 1'b0;
			end
			FOP_ADD, FOP_SUB: begin
				spec = 1'b1;
				if (a_nan) spec_val = a_q | QUIET_BIT;
				else if (b_nan) spec_val = b_q | QUIET_BIT;
				else if (a_inf && b_inf && (a_q[31] != bx[31])) spec_val = QNAN_BITS;
				else if (a_inf) spec_val = a_q;
				else if (b_inf) spec_val = bx;
				else spec = 1'b0;
			end
			FOP_RCP: begin
				spec = 1'b1;
				if (a_nan) spec_val = a_q | QUIET_BIT;
				else if (a_inf) spec_val = {a_q[31], 31'h0};
				else if (a_zero) spec_val = {a_q[31], 8'hFF, 23'h0};
				else spec = 1'b0;
			end
			FOP_NEG: begin
				spec = 1'b1;
				spec_val = {~a_q[31], a_q[30:0]};
			end
			default: spec = 1'b1;
		endcase

		// one quotient bit per cycle
		div_ge = rem_q >= {1'b0, sa};
		div_diff = div_ge ? (rem_q - {1'b0, sa}) : rem_q;

		// normalise, or denormalise below the smallest exponent
		lz_ext = $signed({5'b00000, lz_q});
		rs_full = 11'(-e_q);
		rs6 = (rs_full > 11'd48) ? 6'd48 : rs_full[5:0];
		rs_wide = {m_q, 48'h0} >> rs6;
		if (lz_ext <= e_q) begin
			sh_n = m_q << lz_q;
			sh_x = e_q + 11'sd1 - lz_ext;
			sh_st = st_q;
		end else if (e_q >= 11'sd0) begin
			sh_n = m_q << e_q[5:0];
			sh_x = 11'sd1;
			sh_st = st_q;
		end else begin
			sh_n = rs_wide[95:48];
			sh_x = 11'sd1;
			sh_st = st_q | (|rs_wide[47:0]);
		end

		// round and pack
		keep = n_q[47:24];
		rnd_up = n_q[23] & ((|n_q[22:0]) | nst_q | keep[0]);
		r25 = {1'b0, keep} + {24'h0, rnd_up};
		if (r25[24]) begin
			mant = r25[24:1];
			xr = x_q + 11'sd1;
		end else begin
			mant = r25[23:0];
			xr = x_q;
		end
		if (!mant[23]) packed_res = {sgn_q, 8'h00, mant[22:0]};
		else if (xr >= 11'sd255) packed_res = {sgn_q, 8'hFF, 23'h0};
		else packed_res = {sgn_q, xr[7:0], mant[22:0]};

		state_d = state_q;
		case (state_q)
			F_IDLE: if (req.start) state_d = F_CALC;
			F_CALC: begin
				if (spec) state_d = F_IDLE;
				else if (op_q == FOP_RCP) state_d = F_DIV;
				else state_d = F_LZC;
			end
			F_DIV: if (cnt_q == 6'd0) state_d = F_LZC;
			F_LZC: state_d = F_SHIFT;
			F_SHIFT: state_d = F_ROUND;
			F_ROUND: state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= ((state_q == F_CALC) && spec) || (state_q == F_ROUND);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (req.start) begin
					op_q <= req.op;
					a_q <= req.a;
					b_q <= req.b;
				end
			end
			F_CALC: begin
				if (spec) begin
					res_q <= spec_val;
				end else if (op_q == FOP_RCP) begin
					rem_q <= 25'h080_0000;
					cnt_q <= 6'd47;
					m_q <= 48'h0;
					e_q <= 11'sd253 - $signed({3'b000, ea_e});
					sgn_q <= a_q[31];
				end else if (op_q == FOP_MUL) begin
					m_q <= prod;
					e_q <= mul_e;
					sgn_q <= a_q[31] ^ b_q[31];
					st_q <= 1'b0;
				end else begin
					m_q <= sum;
					e_q <= $signed({3'b000, e_big});
					sgn_q <= sum_sgn;
					st_q <= 1'b0;
				end
			end
			F_DIV: begin
				m_q <= {m_q[46:0], div_ge};
				rem_q <= {div_diff[23:0], 1'b0};
				cnt_q <= cnt_q - 6'd1;
				st_q <= (div_diff != 25'h0);
			end
			F_LZC: lz_q <= lzc48(m_q);
			F_SHIFT: begin
				n_q <= sh_n;
				x_q <= sh_x;
				nst_q <= sh_st;
			end
			F_ROUND: res_q <= packed_res;
			default: ;
		endcase
	end

endmodule
